// ----- hdl/mono_bitmap_pixel_tripler_core_defines.svh -----
// assertion macros for the mono bitmap pixel tripler
`ifndef MONO_BITMAP_PIXEL_TRIPLER_CORE_DEFINES_SVH
`define MONO_BITMAP_PIXEL_TRIPLER_CORE_DEFINES_SVH

// same-cycle implication
`define MBPT_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define MBPT_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- hdl/mbpt_pkg.sv -----
// shared types and constants for the mono bitmap pixel tripler
package mbpt_pkg;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int CSR_BITS       = 12;
   localparam int ROW_WIDTH_RESET = 8;

   typedef struct packed {
      logic [31:0] host_word;
      logic        last_word;
   } word_type;

   typedef struct packed {
      logic     push_a;
      logic     push_b;
      word_type word_a;
      word_type word_b;
   } pack_out_type;

   typedef struct packed {
      logic [QUEUE_PTR_BITS:0] count;
      logic                    room;
   } queue_status_type;

endpackage

// ----- hdl/mbpt_if.sv -----
// valid/ready channel interfaces for bitmap bytes and host words
interface mbpt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] bitmap_byte;
   logic       last_byte;

   modport source (output valid, output bitmap_byte, output last_byte, input ready);
   modport sink (input valid, input bitmap_byte, input last_byte, output ready);
endinterface

interface mbpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] host_word;
   logic        last_word;

   modport source (output valid, output host_word, output last_word, input ready);
   modport sink (input valid, input host_word, input last_word, output ready);
endinterface

// ----- hdl/mono_bitmap_pixel_tripler_core.sv -----
// mono bitmap pixel tripler: 1-bpp bytes in, tripled pixels packed into 32-bit host words out
// path: an input item is held in the input register, then written into the result queue that drives rsp_bus
// throughput: one input item per cycle while each item yields at most one word and rsp_bus.ready stays high
// an item that yields two words (full word plus final flush) pushes both at once; rsp_bus presents them one by one
// reset: synchronous, active high; clears queue and row state, row width returns to 8
`include "mono_bitmap_pixel_tripler_core_defines.svh"
module mono_bitmap_pixel_tripler_core
   import mbpt_pkg::*;
#(
   parameter int WIDTH_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   mbpt_req_if.sink            req_bus,
   mbpt_rsp_if.source          rsp_bus,
   input  logic                csr_write_enable,
   input  logic [CSR_BITS-1:0] csr_write_data
);

   logic [WIDTH_BITS-1:0] row_width_ff, row_width_in;
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_last_ff;
   logic                  accept;
   logic                  advance;
   pack_out_type          pack_out;
   queue_status_type      status;

   assign advance       = in_valid_ff && status.room;
   assign req_bus.ready = !in_valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      row_width_in = csr_write_enable ? WIDTH_BITS'(csr_write_data) : row_width_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_bus.bitmap_byte;
         in_last_ff <= req_bus.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= WIDTH_BITS'(ROW_WIDTH_RESET);
         in_valid_ff  <= 1'b0;
      end else begin
         row_width_ff <= row_width_in;
         in_valid_ff  <= in_valid_in;
      end
   end

   mbpt_packer #(
      .WIDTH_BITS(WIDTH_BITS)
   ) u_packer (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .bitmap_byte(in_byte_ff),
      .last_byte  (in_last_ff),
      .row_width  (row_width_ff),
      .pack_out   (pack_out)
   );

   mbpt_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .pack_out(pack_out),
      .rsp_bus (rsp_bus),
      .status  (status)
   );

   `MBPT_ASSERT_NOW(a_room_on_push, clock, reset, pack_out.push_a || pack_out.push_b, status.count <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 2), "queue pushed without room for two words")
   `MBPT_ASSERT_NOW(a_flush_second, clock, reset, pack_out.push_b, pack_out.push_a && !pack_out.word_a.last_word && pack_out.word_b.last_word, "second word is not a closing flush")
   `MBPT_ASSERT_NEXT(a_word_visible, clock, reset, pack_out.push_a, rsp_bus.valid, "pushed word not presented")

endmodule

// ----- hdl/mbpt_packer.sv -----
// pixel tripling, row tracking and little-endian word packing
module mbpt_packer
   import mbpt_pkg::*;
#(
   parameter int WIDTH_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            bitmap_byte,
   input  logic                  last_byte,
   input  logic [WIDTH_BITS-1:0] row_width,
   output pack_out_type          pack_out
);

   logic [WIDTH_BITS:0] pixels_left_ff, pixels_left_in;
   logic                at_row_start_ff, at_row_start_in;
   logic [23:0]         pending_bytes_ff, pending_bytes_in;
   logic [1:0]          pending_count_ff, pending_count_in;

   logic [WIDTH_BITS:0] row_pixels;
   logic [WIDTH_BITS:0] cur_pixels;
   logic [WIDTH_BITS:0] rest_pixels;
   logic [3:0]          take;
   logic [23:0]         tripled;
   logic [23:0]         new_le;
   logic [4:0]          byte_sum;
   logic [1:0]          nbytes;
   logic [47:0]         combined;
   logic [2:0]          total;
   logic                full;
   logic [23:0]         leftover;
   logic [1:0]          left_count;

   always_comb begin
      row_pixels = (row_width == '0) ? {1'b1, {WIDTH_BITS{1'b0}}} : {1'b0, row_width};
      cur_pixels = at_row_start_ff ? row_pixels : pixels_left_ff;
      take = (cur_pixels < (WIDTH_BITS+1)'(8)) ? cur_pixels[3:0] : 4'd8;
      rest_pixels = cur_pixels - (WIDTH_BITS+1)'(take);

      for (int i = 0; i < 8; i++) begin
         tripled[23-3*i -: 3] = ((4'(i) < take) && bitmap_byte[7-i]) ? 3'b111 : 3'b000;
      end

      byte_sum = 5'(take) * 5'd3 + 5'd7;
      nbytes   = byte_sum[4:3];
      new_le   = {tripled[7:0], tripled[15:8], tripled[23:16]};
      combined = {24'b0, pending_bytes_ff} | ({24'b0, new_le} << {pending_count_ff, 3'b000});
      total    = {1'b0, pending_count_ff} + {1'b0, nbytes};
      full     = total[2];
      leftover = full ? {8'b0, combined[47:32]} : combined[23:0];
      left_count = total[1:0];
   end

   // full word goes first, any zero-filled flush after it
   always_comb begin
      pack_out.push_a = advance && (full || (last_byte && (left_count != 2'd0)));
      pack_out.push_b = advance && full && last_byte && (left_count != 2'd0);
      if (full) begin
         pack_out.word_a.host_word = combined[31:0];
         pack_out.word_a.last_word = last_byte && (left_count == 2'd0);
      end else begin
         pack_out.word_a.host_word = {8'b0, leftover};
         pack_out.word_a.last_word = 1'b1;
      end
      pack_out.word_b.host_word = {8'b0, leftover};
      pack_out.word_b.last_word = 1'b1;
   end

   always_comb begin
      pixels_left_in   = pixels_left_ff;
      at_row_start_in  = at_row_start_ff;
      pending_bytes_in = pending_bytes_ff;
      pending_count_in = pending_count_ff;
      if (advance) begin
         if (last_byte) begin
            pixels_left_in   = '0;
            at_row_start_in  = 1'b1;
            pending_bytes_in = '0;
            pending_count_in = '0;
         end else begin
            pixels_left_in   = rest_pixels;
            at_row_start_in  = (rest_pixels == '0);
            pending_bytes_in = leftover;
            pending_count_in = left_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixels_left_ff   <= '0;
         at_row_start_ff  <= 1'b1;
         pending_bytes_ff <= '0;
         pending_count_ff <= '0;
      end else begin
         pixels_left_ff   <= pixels_left_in;
         at_row_start_ff  <= at_row_start_in;
         pending_bytes_ff <= pending_bytes_in;
         pending_count_ff <= pending_count_in;
      end
   end

endmodule

// ----- hdl/mbpt_queue.sv -----
// four-entry result queue taking up to two words per cycle
module mbpt_queue
   import mbpt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  pack_out_type     pack_out,
   mbpt_rsp_if.source       rsp_bus,
   output queue_status_type status
);

   word_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_next;
   logic                      pop;

   assign pop               = rsp_bus.valid && rsp_bus.ready;
   assign rsp_bus.valid     = (count_ff != '0);
   assign rsp_bus.host_word = entry_ff[rd_ptr_ff].host_word;
   assign rsp_bus.last_word = entry_ff[rd_ptr_ff].last_word;
   assign wr_ptr_next       = wr_ptr_ff + 1'b1;

   assign status.count = count_ff;
   assign status.room  = (count_ff <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(pack_out.push_a) + QUEUE_PTR_BITS'(pack_out.push_b);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
      count_in  = count_ff + (QUEUE_PTR_BITS+1)'(pack_out.push_a)
                  + (QUEUE_PTR_BITS+1)'(pack_out.push_b) - (QUEUE_PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (pack_out.push_a) begin
         entry_ff[wr_ptr_ff] <= pack_out.word_a;
      end
      if (pack_out.push_b) begin
         entry_ff[wr_ptr_next] <= pack_out.word_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
